// ----- src/spq_pkg.sv -----
// Shared types and constants for the stable priority queue unit.
// No dependencies; imported by the channel interfaces, the queue unit and the testbench.
package spq_pkg;

   // Default queue depth and fixed field widths
   localparam int DEPTH_DEFAULT = 16;
   localparam int PRI_W         = 8;
   localparam int TAG_W         = 16;
   localparam int OCC_W         = 5;

   // Operation codes carried on the request channel
   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_POP    = 1'b1
   } op_type;

   // One stored queue entry
   typedef struct packed {
      logic [PRI_W-1:0] pri;
      logic [TAG_W-1:0] tag;
   } entry_type;

endpackage

// ----- src/spq_if.sv -----
// Valid/ready channel interfaces for request and response transactions.
// Depends on spq_pkg for field widths and the operation code type.
interface spq_req_if import spq_pkg::*; ();
   logic             valid;
   logic             ready;
   op_type           op;
   logic [PRI_W-1:0] priority_req;
   logic [TAG_W-1:0] patient_tag;

   modport source (output valid, op, priority_req, patient_tag, input ready);
   modport sink   (input valid, op, priority_req, patient_tag, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             out_valid;
   logic [TAG_W-1:0] out_tag;
   logic [PRI_W-1:0] out_priority;
   logic             is_empty;
   logic             is_full;
   logic             dropped;
   logic [OCC_W-1:0] occupancy;

   modport source (output valid, out_valid, out_tag, out_priority, is_empty, is_full,
                   dropped, occupancy, input ready);
   modport sink   (input valid, out_valid, out_tag, out_priority, is_empty, is_full,
                   dropped, occupancy, output ready);
endinterface

// ----- src/stable_priority_queue_unit.sv -----
// Stable priority queue: sorted circular buffer in RAM, lowest priority served first.
// An insert walks from the tail through the stored entries with a greater priority, one
// RAM read/compare/write each, then places the new entry; a pop reads the head entry; a
// refused insert or a pop on an empty queue goes straight to the response.
// Throughput: one transaction at a time; req ready only while the sequencer is idle, after
// the response has been loaded; a held response stalls the next one at its load.
// Reset: synchronous, active high; clears count, head and handshake state, not storage.
module stable_priority_queue_unit import spq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic   clock,
   input  logic   reset,
   spq_req_if.sink   req_if,
   spq_rsp_if.source rsp_if
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_START = 6'b000010,
      ST_SCAN  = 6'b000100,
      ST_PLACE = 6'b001000,
      ST_POPD  = 6'b010000,
      ST_RESP  = 6'b100000
   } state_type;

   // Wrapping pointer steps
   function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      r = (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
      return r;
   endfunction

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
      return r;
   endfunction

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] src_ff, src_in;
   logic [PTR_W-1:0] dst_ff, dst_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   op_type           op_ff;
   entry_type        new_ff;
   logic             res_valid_ff, res_valid_in;
   entry_type        res_entry_ff, res_entry_in;
   logic             res_drop_ff, res_drop_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_load;

   logic             out_valid_ff;
   logic [TAG_W-1:0] out_tag_ff;
   logic [PRI_W-1:0] out_priority_ff;
   logic             is_empty_ff;
   logic             is_full_ff;
   logic             dropped_ff;
   logic [OCC_W-1:0] occupancy_ff;

   logic [SUM_W-1:0] tail_sum;
   logic [PTR_W-1:0] tail;
   logic             req_accept;
   logic             ram_wr_en;
   logic [PTR_W-1:0] ram_wr_addr;
   entry_type        ram_wr_data;
   logic [PTR_W-1:0] ram_rd_addr;
   entry_type        ram_rd_data;

   // Physical slot just past the last live entry
   assign tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail     = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
                                                 : PTR_W'(tail_sum);

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;
   assign rsp_load     = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_if.ready);

   spq_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Sequencer: inserts walk from the tail toward the head, shifting larger entries up one slot; pops read the head
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      rem_in       = rem_ff;
      res_valid_in = res_valid_ff;
      res_entry_in = res_entry_ff;
      res_drop_in  = res_drop_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = dst_ff;
      ram_wr_data  = new_ff;
      ram_rd_addr  = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            res_valid_in = 1'b0;
            res_entry_in = '0;
            res_drop_in  = 1'b0;
            if (op_ff == OP_INSERT) begin
               if (count_ff == CNT_W'(DEPTH)) begin
                  res_drop_in = 1'b1;
                  state_in    = ST_RESP;
               end else if (count_ff == '0) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = tail;
                  count_in    = count_ff + 1'b1;
                  state_in    = ST_RESP;
               end else begin
                  ram_rd_addr = ptr_dec(tail);
                  src_in      = ptr_dec(tail);
                  dst_in      = tail;
                  rem_in      = count_ff;
                  state_in    = ST_SCAN;
               end
            end else begin
               if (count_ff == '0) begin
                  state_in = ST_RESP;
               end else begin
                  ram_rd_addr = head_ff;
                  state_in    = ST_POPD;
               end
            end
         end
         ST_SCAN: begin
            ram_wr_en = 1'b1;
            if (ram_rd_data.pri > new_ff.pri) begin
               // Shift this entry up and keep walking
               ram_wr_data = ram_rd_data;
               dst_in      = src_ff;
               rem_in      = rem_ff - 1'b1;
               ram_rd_addr = ptr_dec(src_ff);
               src_in      = ptr_dec(src_ff);
               if (rem_ff == CNT_W'(1)) begin
                  state_in = ST_PLACE;
               end
            end else begin
               // Place the new entry after the last one not greater
               count_in = count_ff + 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_PLACE: begin
            ram_wr_en = 1'b1;
            count_in  = count_ff + 1'b1;
            state_in  = ST_RESP;
         end
         ST_POPD: begin
            res_valid_in = 1'b1;
            res_entry_in = ram_rd_data;
            head_in      = ptr_inc(head_ff);
            count_in     = count_ff - 1'b1;
            state_in     = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the response until the sink takes the transaction
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      src_ff       <= src_in;
      dst_ff       <= dst_in;
      rem_ff       <= rem_in;
      res_valid_ff <= res_valid_in;
      res_entry_ff <= res_entry_in;
      res_drop_ff  <= res_drop_in;
      if (req_accept) begin
         op_ff      <= req_if.op;
         new_ff.pri <= req_if.priority_req;
         new_ff.tag <= req_if.patient_tag;
      end
      if (rsp_load) begin
         out_valid_ff    <= res_valid_ff;
         out_tag_ff      <= res_entry_ff.tag;
         out_priority_ff <= res_entry_ff.pri;
         is_empty_ff     <= (count_ff == '0);
         is_full_ff      <= (count_ff == CNT_W'(DEPTH));
         dropped_ff      <= res_drop_ff;
         occupancy_ff    <= OCC_W'(count_ff);
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.out_valid    = out_valid_ff;
   assign rsp_if.out_tag      = out_tag_ff;
   assign rsp_if.out_priority = out_priority_ff;
   assign rsp_if.is_empty     = is_empty_ff;
   assign rsp_if.is_full      = is_full_ff;
   assign rsp_if.dropped      = dropped_ff;
   assign rsp_if.occupancy    = occupancy_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds depth");

   a_scan_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (rem_ff != '0) && (count_ff != CNT_W'(DEPTH)))
      else $error("scan running with nothing left or queue full");

   a_pop_not_full: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.out_valid |-> !rsp_if.is_full && !rsp_if.dropped)
      else $error("popped response reports full or dropped");

   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_START))
      else $error("accepted transaction did not start the sequencer");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) && (state_ff != ST_RESP) && !$past(reset) |->
      (count_ff == $past(count_ff)) || (state_ff == ST_SCAN))
      else $error("count changed outside an operation");

endmodule

// ----- src/spq_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module spq_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write, and register the read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for stable_priority_queue_unit: directed corners, random traffic.
// Depends on spq_pkg and the spq_req_if / spq_rsp_if channel interfaces.
`timescale 1ns / 1ps

module tb;
   import spq_pkg::*;

   localparam int DEPTH          = DEPTH_DEFAULT;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int END_TAIL       = 30;
   localparam int LONG_HOLD      = 400;

   typedef struct packed {
      logic             out_valid;
      logic [TAG_W-1:0] out_tag;
      logic [PRI_W-1:0] out_priority;
      logic             is_empty;
      logic             is_full;
      logic             dropped;
      logic [OCC_W-1:0] occupancy;
   } queue_status_type;

   logic clock;
   logic reset;

   spq_req_if req_ch ();
   spq_rsp_if rsp_ch ();

   stable_priority_queue_unit #(.DEPTH(DEPTH)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Predicted queue contents, head first, and status words still to arrive
   entry_type        queue_image[$];
   queue_status_type awaited_status[$];

   int mismatch_count;
   int ops_sent;
   int pops_served;
   int pops_on_empty;
   int inserts_refused;
   int peak_occupancy;
   int quiet_cycles;

   // Idle controls for the sender and the receiver
   int send_gap_pct;
   int recv_stall_pct;
   int long_hold_cycles;
   int stall_left;

   // Set while the last accepted request is still driven with valid high
   bit req_held;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(12, 40);
      return $urandom_range(1, 3);
   endfunction

   // Apply one operation to the queue image and return the status it produces
   function automatic queue_status_type step_queue_image(input op_type op,
                                                         input logic [PRI_W-1:0] pri,
                                                         input logic [TAG_W-1:0] tag);
      queue_status_type st;
      entry_type        e;
      int               pos;
      st = '0;
      if (op == OP_INSERT) begin
         if (queue_image.size() >= DEPTH) begin
            st.dropped = 1'b1;
            inserts_refused++;
         end else begin
            // Place after every entry that is not greater, so ties keep arrival order
            pos = 0;
            while (pos < queue_image.size() && queue_image[pos].pri <= pri)
               pos++;
            e.pri = pri;
            e.tag = tag;
            queue_image.insert(pos, e);
         end
      end else if (queue_image.size() > 0) begin
         e = queue_image.pop_front();
         st.out_valid    = 1'b1;
         st.out_tag      = e.tag;
         st.out_priority = e.pri;
         pops_served++;
      end else begin
         pops_on_empty++;
      end
      st.is_empty  = (queue_image.size() == 0);
      st.is_full   = (queue_image.size() >= DEPTH);
      st.occupancy = OCC_W'(queue_image.size());
      if (queue_image.size() > peak_occupancy)
         peak_occupancy = queue_image.size();
      return st;
   endfunction

   // Offer one transaction, hold it until accepted, then maybe idle
   task automatic issue_op(input op_type op, input logic [PRI_W-1:0] pri,
                           input logic [TAG_W-1:0] tag);
      int gap;
      req_ch.valid        <= 1'b1;
      req_ch.op           <= op;
      req_ch.priority_req <= pri;
      req_ch.patient_tag  <= tag;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      awaited_status.push_back(step_queue_image(op, pri, tag));
      ops_sent++;
      if ($urandom_range(0, 99) < send_gap_pct) begin
         gap = pick_gap();
         req_held = 1'b0;
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end else begin
         req_held = 1'b1;
      end
   endtask

   // Stop offering and wait for every outstanding response
   task automatic wait_for_drain();
      if (req_held)
         req_ch.valid <= 1'b0;
      req_held = 1'b0;
      while (awaited_status.size() != 0)
         @(posedge clock);
   endtask

   task automatic issue_random(input int insert_pct, input int pri_lo, input int pri_hi);
      op_type op;
      op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_POP;
      issue_op(op, PRI_W'($urandom_range(pri_hi, pri_lo)), TAG_W'($urandom_range(16'hFFFF, 0)));
   endtask

   // Pops on an empty queue right after reset
   task automatic test_empty_pops();
      issue_op(OP_POP, 8'hFF, 16'hFFFF);
      issue_op(OP_POP, 8'h00, 16'h0000);
   endtask

   // Fill with extreme and tied priorities, refuse one insert, pop the three tied head entries and the next one
   task automatic test_fill_and_refuse();
      logic [PRI_W-1:0] pris[16] = '{8'd128, 8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd7,
                                     8'd128, 8'd1, 8'd254, 8'd0, 8'd128, 8'd64, 8'd255,
                                     8'd3, 8'd128};
      logic [TAG_W-1:0] tags[16] = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555, 16'h0001,
                                     16'h8000, 16'h1234, 16'hFEDC, 16'h0F0F, 16'hF0F0,
                                     16'h7FFF, 16'h00FF, 16'hFF00, 16'h3C3C, 16'hC3C3,
                                     16'h0002};
      foreach (pris[i])
         issue_op(OP_INSERT, pris[i], tags[i]);
      issue_op(OP_INSERT, 8'h00, 16'hBEEF);
      repeat (4) issue_op(OP_POP, 8'h00, 16'h0000);
   endtask

   // Random traffic with a bias toward filling or draining
   task automatic test_random_traffic(input int count, input int insert_pct,
                                      input int pri_lo, input int pri_hi);
      repeat (count) issue_random(insert_pct, pri_lo, pri_hi);
   endtask

   // Hold the receiver off for a long stretch while the sender keeps offering
   task automatic test_stalled_receiver();
      int saved_gap;
      saved_gap        = send_gap_pct;
      send_gap_pct     = 0;
      long_hold_cycles = LONG_HOLD;
      repeat (12) issue_random(60, 0, 255);
      send_gap_pct = saved_gap;
   endtask

   // Let every response come back before sending more
   task automatic test_sender_pause();
      repeat (6) issue_random(50, 0, 255);
      wait_for_drain();
      repeat (6) issue_random(50, 0, 255);
   endtask

   // Receiver: random stalls, plus a long hold when one is requested
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (long_hold_cycles > 0) begin
            stall_left       = long_hold_cycles - 1;
            long_hold_cycles = 0;
            rsp_ch.ready <= 1'b0;
         end else if ($urandom_range(0, 99) < recv_stall_pct) begin
            stall_left = pick_gap() - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Compare each response transaction against the oldest prediction
   always @(posedge clock) begin
      queue_status_type got;
      queue_status_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
         got.out_valid    = rsp_ch.out_valid;
         got.out_tag      = rsp_ch.out_tag;
         got.out_priority = rsp_ch.out_priority;
         got.is_empty     = rsp_ch.is_empty;
         got.is_full      = rsp_ch.is_full;
         got.dropped      = rsp_ch.dropped;
         got.occupancy    = rsp_ch.occupancy;
         if (awaited_status.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: response with no transaction pending", $time);
         end else begin
            want = awaited_status.pop_front();
            if (got.out_valid !== want.out_valid || got.out_tag !== want.out_tag ||
                got.out_priority !== want.out_priority || got.is_empty !== want.is_empty ||
                got.is_full !== want.is_full || got.dropped !== want.dropped ||
                got.occupancy !== want.occupancy) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: exp valid=%b tag=%h pri=%0d empty=%b full=%b drop=%b occ=%0d",
                           $time, want.out_valid, want.out_tag, want.out_priority,
                           want.is_empty, want.is_full, want.dropped, want.occupancy);
                  $display("%0t: got valid=%b tag=%h pri=%0d empty=%b full=%b drop=%b occ=%0d",
                           $time, got.out_valid, got.out_tag, got.out_priority,
                           got.is_empty, got.is_full, got.dropped, got.occupancy);
               end
            end
         end
      end
   end

   // Watchdog: end the run after too long without any transaction
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d quiet cycles, %0d responses outstanding",
                  quiet_cycles, awaited_status.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Sequence the tests
   initial begin
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.op           <= OP_INSERT;
      req_ch.priority_req <= '0;
      req_ch.patient_tag  <= '0;
      send_gap_pct     = 30;
      recv_stall_pct   = 20;
      long_hold_cycles = 0;
      stall_left       = 0;
      req_held         = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_empty_pops();
      test_fill_and_refuse();

      send_gap_pct   = 20;
      recv_stall_pct = 20;
      test_random_traffic(250, 60, 0, 255);

      // Narrow priorities for many ties, no idling
      send_gap_pct   = 0;
      recv_stall_pct = 0;
      test_random_traffic(250, 50, 0, 3);

      // Drain-heavy with heavy idling
      send_gap_pct   = 50;
      recv_stall_pct = 50;
      test_random_traffic(200, 35, 0, 255);

      // Fill-heavy so inserts hit a full queue
      send_gap_pct   = 15;
      recv_stall_pct = 15;
      test_random_traffic(250, 70, 0, 255);

      test_stalled_receiver();
      test_sender_pause();

      send_gap_pct   = 30;
      recv_stall_pct = 30;
      test_random_traffic(200, 50, 0, 255);

      wait_for_drain();
      repeat (END_TAIL) @(posedge clock);

      $display("Ran %0d transactions: %0d pops served, %0d pops on empty, %0d inserts refused,",
               ops_sent, pops_served, pops_on_empty, inserts_refused);
      $display("peak occupancy %0d of %0d, %0d mismatches.",
               peak_occupancy, DEPTH, mismatch_count);
      if (mismatch_count == 0 && awaited_status.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
